>>> rtl/nmea_pkg.sv
// ============================================================================
// nmea_pkg
// Shared types and constants for the NMEA sentence field extractor.
// ============================================================================
package nmea_pkg;

    // longest line taken, in bytes
    localparam int LINE_LIMIT_DEF = 127;

    // comma counter saturation value
    localparam logic [6:0] COMMA_MAX = 7'd127;

    // header progress codes
    localparam logic [2:0] HP_DONE = 3'd6;
    localparam logic [2:0] HP_FAIL = 3'd7;
    localparam logic [2:0] HP_KIND = 3'd3;

    // mode register codes
    localparam logic [1:0] MODE_NONE     = 2'd0;
    localparam logic [1:0] MODE_POSITION = 2'd1;
    localparam logic [1:0] MODE_ALTITUDE = 2'd2;
    localparam logic [1:0] MODE_SPEED    = 2'd3;
    localparam logic [1:0] MODE_RESET    = MODE_POSITION;

    // special characters
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_G       = 8'h47;
    localparam logic [7:0] CH_V       = 8'h56;

    // sentence kind
    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_GGA  = 2'd1,
        KIND_VTG  = 2'd2
    } t_kind;

    // expected header byte for a kind at a header position
    function automatic logic [7:0] hdr_char(input t_kind kind, input logic [2:0] pos);
        logic [7:0] ch;
        begin
            case (pos)
                3'd0: ch = 8'h24;                                  // '$'
                3'd1: ch = 8'h47;                                  // 'G'
                3'd2: ch = 8'h50;                                  // 'P'
                3'd3: ch = (kind == KIND_VTG) ? 8'h56 : 8'h47;     // 'V' / 'G'
                3'd4: ch = (kind == KIND_VTG) ? 8'h54 : 8'h47;     // 'T' / 'G'
                3'd5: ch = (kind == KIND_VTG) ? 8'h47 : 8'h41;     // 'G' / 'A'
                default: ch = 8'h00;
            endcase
            return ch;
        end
    endfunction

endpackage

>>> rtl/nmea_sentence_field_extractor_top.sv
// ============================================================================
// nmea_sentence_field_extractor_top
// Picks the characters of selected fields out of NMEA GGA / VTG sentences.
// ============================================================================
// Takes one received byte per cycle with no gaps required unless the output
// stalls. A byte is held in the input register, then the header match, comma
// count and field select run in a single pass into the result register, from
// which the result leaves; the sustained rate is one byte per clock. The
// input stalls only while the result register is full and held by the
// output stall. Mode 1 gives GGA fields 2 to 5, mode 2 GGA field
// 9, mode 3 VTG field 7; a newline after a matching sentence gives an end
// marker with a zero character. The header must start a line, text after the
// first '*' is dropped, and bytes past LINE_LIMIT in a line are ignored. Write
// the mode only while no bytes are in flight.
module nmea_sentence_field_extractor_top
    import nmea_pkg::*;
#(
    parameter int LINE_LIMIT = LINE_LIMIT_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // byte input channel
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_rx_byte,
    // result channel
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_field_char,
    output logic [3:0] o_field_number,
    output logic       o_end_of_sentence,
    // mode register write channel
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_mode
);

    localparam int LP_W = $clog2(LINE_LIMIT + 1);
    localparam logic [LP_W-1:0] LP_MAX = LP_W'(LINE_LIMIT);

    logic [1:0]      r_mode;
    logic            r_in_valid;
    logic [7:0]      r_in_byte;
    logic [LP_W-1:0] r_line_pos,  n_line_pos;
    logic [2:0]      r_hdr,       n_hdr;
    t_kind           r_kind,      n_kind;
    logic [6:0]      r_comma,     n_comma;
    logic            r_star,      n_star;
    logic            r_out_valid;
    logic [7:0]      r_out_char;
    logic [3:0]      r_out_num;
    logic            r_out_eos;
    logic            res_valid;
    logic [7:0]      res_char;
    logic [3:0]      res_num;
    logic            res_eos;
    logic            advance;
    logic            sent_sel;
    logic            field_sel;

    // pipeline moves when the result register is free or being taken
    assign advance     = !r_out_valid || !i_out_stall;
    assign o_in_stall  = r_in_valid && !advance;
    assign o_cfg_ready = 1'b1;

    // mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_mode <= i_cfg_mode;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // per-byte line state update and result select
    always_comb begin
        n_line_pos = r_line_pos;
        n_hdr      = r_hdr;
        n_kind     = r_kind;
        n_comma    = r_comma;
        n_star     = r_star;
        res_valid  = 1'b0;
        res_char   = r_in_byte;
        res_num    = r_comma[3:0];
        res_eos    = 1'b0;
        sent_sel   = 1'b0;
        field_sel  = 1'b0;

        if (r_in_byte == CH_NEWLINE) begin
            // end of line: marker if the finished sentence was selected
            if (r_hdr == HP_DONE) begin
                case (r_kind)
                    KIND_GGA: sent_sel = (r_mode == MODE_POSITION) ||
                                         (r_mode == MODE_ALTITUDE);
                    KIND_VTG: sent_sel = (r_mode == MODE_SPEED);
                    default:  sent_sel = 1'b0;
                endcase
            end
            res_valid  = sent_sel;
            res_char   = 8'h00;
            res_num    = 4'd0;
            res_eos    = sent_sel;
            n_line_pos = '0;
            n_hdr      = 3'd0;
            n_kind     = KIND_NONE;
            n_comma    = 7'd0;
            n_star     = 1'b0;
        end else if (r_line_pos < LP_MAX) begin
            n_line_pos = r_line_pos + LP_W'(1);

            // header match at the start of the line
            if (r_hdr < HP_DONE) begin
                if (r_hdr == HP_KIND) begin
                    if (r_in_byte == CH_G) begin
                        n_kind = KIND_GGA;
                        n_hdr  = r_hdr + 3'd1;
                    end else if (r_in_byte == CH_V) begin
                        n_kind = KIND_VTG;
                        n_hdr  = r_hdr + 3'd1;
                    end else begin
                        n_kind = KIND_NONE;
                        n_hdr  = HP_FAIL;
                    end
                end else if (r_in_byte == hdr_char(r_kind, r_hdr)) begin
                    n_hdr = r_hdr + 3'd1;
                end else begin
                    n_kind = KIND_NONE;
                    n_hdr  = HP_FAIL;
                end
            end

            // selection with the header state after this byte
            if (n_hdr == HP_DONE) begin
                case (n_kind)
                    KIND_GGA: sent_sel = (r_mode == MODE_POSITION) ||
                                         (r_mode == MODE_ALTITUDE);
                    KIND_VTG: sent_sel = (r_mode == MODE_SPEED);
                    default:  sent_sel = 1'b0;
                endcase
            end
            case (r_mode)
                MODE_POSITION: field_sel = (r_comma >= 7'd2) && (r_comma <= 7'd5);
                MODE_ALTITUDE: field_sel = (r_comma == 7'd9);
                MODE_SPEED:    field_sel = (r_comma == 7'd7);
                default:       field_sel = 1'b0;
            endcase

            // field scan up to the checksum
            if (!r_star) begin
                if (r_in_byte == CH_STAR) begin
                    n_star = 1'b1;
                end else if (r_in_byte == CH_COMMA) begin
                    if (r_comma < COMMA_MAX) begin
                        n_comma = r_comma + 7'd1;
                    end
                end else begin
                    res_valid = sent_sel && field_sel;
                end
            end
        end
    end

    // line state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_pos <= '0;
            r_hdr      <= 3'd0;
            r_kind     <= KIND_NONE;
            r_comma    <= 7'd0;
            r_star     <= 1'b0;
        end else if (r_in_valid && advance) begin
            r_line_pos <= n_line_pos;
            r_hdr      <= n_hdr;
            r_kind     <= n_kind;
            r_comma    <= n_comma;
            r_star     <= n_star;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid && res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid && res_valid) begin
            r_out_char <= res_char;
            r_out_num  <= res_num;
            r_out_eos  <= res_eos;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_field_char      = r_out_char;
    assign o_field_number    = r_out_num;
    assign o_end_of_sentence = r_out_eos;

endmodule

>>> rtl/nmea_chk.sv
// ============================================================================
// nmea_chk
// Port-level checks for the NMEA sentence field extractor.
// ============================================================================
module nmea_chk
    import nmea_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic [7:0] i_rx_byte,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_field_char,
    input logic [3:0] o_field_number,
    input logic       o_end_of_sentence
);

    // stalled result transaction holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_field_char) &&
        $stable(o_field_number) && $stable(o_end_of_sentence))
        else $error("stalled result changed");

    // end marker carries zero character and field number
    a_eos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_end_of_sentence |-> o_field_char == 8'h00 &&
        o_field_number == 4'd0)
        else $error("end marker payload not zero");

    // field characters are never separators and carry a selectable number
    a_field_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_end_of_sentence |-> o_field_char != CH_COMMA &&
        o_field_char != CH_STAR && o_field_char != CH_NEWLINE &&
        o_field_number >= 4'd2 && o_field_number <= 4'd9)
        else $error("bad field character transaction");

    // a fresh result reflects the accepted byte that passed through the input register
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && !o_in_stall, 2) &&
        ((o_end_of_sentence && $past(i_rx_byte, 2) == CH_NEWLINE) ||
         (!o_end_of_sentence && $past(i_rx_byte, 2) == o_field_char)))
        else $error("result does not match accepted byte");

endmodule

bind nmea_sentence_field_extractor_top nmea_chk u_nmea_chk (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in_valid),
    .o_in_stall        (o_in_stall),
    .i_rx_byte         (i_rx_byte),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_field_char      (o_field_char),
    .o_field_number    (o_field_number),
    .o_end_of_sentence (o_end_of_sentence)
);

>>> dv/nmea_sentence_field_extractor_top_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// nmea_sentence_field_extractor_top_tb
// Self-checking bench for the NMEA GGA / VTG field extractor.
// ============================================================================
// Feeds byte streams of well-formed, broken and noisy NMEA lines through the
// byte channel under random idling on both sides, and predicts each field
// character and end marker from its own line tracker. Results are compared
// in order, field by field. The mode register is rewritten between phases
// while the block is drained, covering every mode including the unused one.
module nmea_sentence_field_extractor_top_tb;
    import nmea_pkg::*;

    localparam int          TARGET_ITEMS   = 950;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          HOLD_CYCLES    = 120;
    localparam int          HOLD_START     = 600;
    localparam int          SETTLE_CYCLES  = 4;
    localparam int          MAX_LONG_LINES = 3;
    localparam logic [47:0] GGA_TAG        = "$GPGGA";
    localparam logic [47:0] VTG_TAG        = "$GPVTG";

    // one result of the block
    typedef struct packed {
        logic [7:0] ch;
        logic [3:0] num;
        logic       eos;
    } t_field_item;

    logic       i_clk          = 1'b0;
    logic       i_rst_n        = 1'b0;
    logic       i_in_valid     = 1'b0;
    logic       o_in_stall;
    logic [7:0] i_rx_byte      = 8'h00;
    logic       o_out_valid;
    logic       i_out_stall    = 1'b0;
    logic [7:0] o_field_char;
    logic [3:0] o_field_number;
    logic       o_end_of_sentence;
    logic       i_cfg_valid    = 1'b0;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_mode     = MODE_RESET;

    // line tracker state
    logic [1:0] sel_mode   = MODE_RESET;
    int         line_pos   = 0;
    logic [2:0] hdr_prog   = 3'd0;
    t_kind      line_kind  = KIND_NONE;
    logic [6:0] commas     = 7'd0;
    logic       star_seen  = 1'b0;

    logic [7:0]  tx_bytes[$];
    t_field_item pending_fields[$];

    int   taken_seen   = 0;
    int   in_count     = 0;
    int   out_count    = 0;
    int   errors       = 0;
    int   pushed       = 0;
    int   long_lines   = 0;
    int   quiet_cycles = 0;
    int   hold_left    = 0;
    logic hold_done    = 1'b0;

    // no idling on either side through this stretch of the byte stream
    wire steady = (in_count >= 400) && (in_count < 550);

    nmea_sentence_field_extractor_top uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_rx_byte         (i_rx_byte),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_field_char      (o_field_char),
        .o_field_number    (o_field_number),
        .o_end_of_sentence (o_end_of_sentence),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_mode        (i_cfg_mode)
    );

    always #5 i_clk = ~i_clk;

    // current line is a complete header of the kind the mode wants
    function automatic logic sentence_on();
        if (hdr_prog != HP_DONE)
            return 1'b0;
        if (line_kind == KIND_GGA)
            return (sel_mode == MODE_POSITION) || (sel_mode == MODE_ALTITUDE);
        if (line_kind == KIND_VTG)
            return sel_mode == MODE_SPEED;
        return 1'b0;
    endfunction

    function automatic logic field_on(input logic [6:0] f);
        case (sel_mode)
            MODE_POSITION: return (f >= 7'd2) && (f <= 7'd5);
            MODE_ALTITUDE: return f == 7'd9;
            MODE_SPEED:    return f == 7'd7;
            default:       return 1'b0;
        endcase
    endfunction

    // header match, one byte at a time; kind is decided at the fourth byte
    task automatic track_header(input logic [7:0] b);
        logic [47:0] tag;
        if (hdr_prog >= HP_DONE)
            return;
        if (hdr_prog == HP_KIND) begin
            if (b == CH_G) begin
                line_kind = KIND_GGA;
                hdr_prog  = hdr_prog + 3'd1;
            end else if (b == CH_V) begin
                line_kind = KIND_VTG;
                hdr_prog  = hdr_prog + 3'd1;
            end else begin
                line_kind = KIND_NONE;
                hdr_prog  = HP_FAIL;
            end
            return;
        end
        tag = (line_kind == KIND_VTG) ? VTG_TAG : GGA_TAG;
        if (b == tag[47 - 8 * hdr_prog -: 8]) begin
            hdr_prog = hdr_prog + 3'd1;
        end else begin
            line_kind = KIND_NONE;
            hdr_prog  = HP_FAIL;
        end
    endtask

    // predict what one accepted byte produces
    task automatic extract_byte(input logic [7:0] b);
        t_field_item item;
        if (b == CH_NEWLINE) begin
            if (sentence_on()) begin
                item = '{ch: 8'h00, num: 4'd0, eos: 1'b1};
                pending_fields.push_back(item);
            end
            line_pos  = 0;
            hdr_prog  = 3'd0;
            line_kind = KIND_NONE;
            commas    = 7'd0;
            star_seen = 1'b0;
            return;
        end
        if (line_pos >= LINE_LIMIT_DEF)
            return;
        track_header(b);
        line_pos++;
        if (star_seen)
            return;
        if (b == CH_STAR) begin
            star_seen = 1'b1;
            return;
        end
        if (b == CH_COMMA) begin
            if (commas < COMMA_MAX)
                commas = commas + 7'd1;
            return;
        end
        if (sentence_on() && field_on(commas)) begin
            item = '{ch: b, num: commas[3:0], eos: 1'b0};
            pending_fields.push_back(item);
        end
    endtask

    // stimulus helpers
    task automatic push_byte(input logic [7:0] b);
        tx_bytes.push_back(b);
        pushed++;
    endtask

    task automatic push_text(input string txt);
        int k;
        for (k = 0; k < txt.len(); k++)
            push_byte(txt[k]);
    endtask

    // mostly digits and dots, some letters, some arbitrary bytes but newline
    function automatic logic [7:0] field_byte();
        int         r;
        logic [7:0] b;
        r = $urandom_range(0, 99);
        if (r < 60)
            b = 8'h30 + 8'($urandom_range(0, 9));
        else if (r < 70)
            b = 8'h2E;
        else if (r < 80)
            b = 8'h41 + 8'($urandom_range(0, 25));
        else begin
            b = 8'($urandom_range(0, 255));
            if (b == CH_NEWLINE)
                b = 8'h00;
        end
        return b;
    endfunction

    task automatic push_sentence(input logic vtg, input int nfields, input logic broken);
        logic [47:0] tag;
        int          k;
        int          bad;
        tag = vtg ? VTG_TAG : GGA_TAG;
        bad = broken ? int'($urandom_range(0, 5)) : -1;
        for (k = 0; k < 6; k++)
            push_byte(k == bad ? 8'($urandom_range(0, 255)) : tag[47 - 8 * k -: 8]);
        // occasional junk glued onto the header field
        if ($urandom_range(0, 9) == 0)
            push_byte(field_byte());
        for (k = 0; k < nfields; k++) begin
            push_byte(CH_COMMA);
            repeat ($urandom_range(0, 5)) push_byte(field_byte());
        end
        // checksum, sometimes with trailing text that must be dropped
        if ($urandom_range(0, 99) < 80) begin
            push_byte(CH_STAR);
            push_byte(field_byte());
            push_byte(field_byte());
            if ($urandom_range(0, 99) < 30)
                push_text(",9,9");
        end
        push_byte(CH_NEWLINE);
    endtask

    task automatic push_noise_line();
        repeat ($urandom_range(1, 20)) push_byte(8'($urandom_range(0, 255)));
        push_byte(CH_NEWLINE);
    endtask

    // a sentence that runs past the line limit
    task automatic push_long_line(input logic vtg);
        int k;
        int len;
        push_text(vtg ? "$GPVTG" : "$GPGGA");
        len = $urandom_range(130, 180);
        for (k = 6; k < len; k++)
            push_byte(($urandom_range(0, 3) == 0) ? CH_COMMA : field_byte());
        push_byte(CH_NEWLINE);
        long_lines++;
    endtask

    // wait until the block has nothing in flight
    task automatic drain();
        while (tx_bytes.size() != 0 || i_in_valid || pending_fields.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // mode register write transaction
    task automatic write_mode(input logic [1:0] m);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_mode  <= m;
        do @(posedge i_clk); while (!o_cfg_ready);
        sel_mode = m;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // byte driver: next byte or an idle cycle once the current one is taken
    always @(negedge i_clk) begin
        if (!i_in_valid || in_count != taken_seen) begin
            taken_seen = in_count;
            if (tx_bytes.size() != 0 && (steady || $urandom_range(0, 99) >= 25)) begin
                i_in_valid <= 1'b1;
                i_rx_byte  <= tx_bytes.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // input monitor: every accepted byte goes to the line tracker
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            extract_byte(i_rx_byte);
            in_count++;
        end
    end

    // result stall: random, plus one long hold-off on a waiting result
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (!hold_done && o_out_valid && in_count >= HOLD_START) begin
            hold_done   <= 1'b1;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !steady && ($urandom_range(0, 99) < 25);
        end
    end

    // result monitor and compare
    always @(posedge i_clk) begin
        t_field_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            out_count++;
            if (pending_fields.size() == 0) begin
                $display("%0t: unexpected result char=%h num=%0d eos=%b", $time,
                         o_field_char, o_field_number, o_end_of_sentence);
                errors++;
            end else begin
                want = pending_fields.pop_front();
                if (o_field_char !== want.ch) begin
                    $display("%0t: field_char expected %h actual %h", $time,
                             want.ch, o_field_char);
                    errors++;
                end
                if (o_field_number !== want.num) begin
                    $display("%0t: field_number expected %0d actual %0d", $time,
                             want.num, o_field_number);
                    errors++;
                end
                if (o_end_of_sentence !== want.eos) begin
                    $display("%0t: end_of_sentence expected %b actual %b", $time,
                             want.eos, o_end_of_sentence);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no transaction anywhere
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL nmea_sentence_field_extractor_top");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // stimulus sequence
    initial begin
        logic [1:0] phase_modes[6];
        int         budget;
        int         start;
        int         p;
        int         r;

        phase_modes = '{MODE_SPEED, MODE_POSITION, MODE_NONE,
                        MODE_ALTITUDE, MODE_POSITION, MODE_SPEED};

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // position mode from reset, with null and all-ones bytes in a field
        push_text("$GPGGA,12,4916.4");
        push_byte(8'h00);
        push_byte(8'hFF);
        push_text(",N,1,W*7,5\n");
        // empty line, header not at line start, wrong kind, failed header
        push_text("\n $GPGGA,1,2,3\n$GPVTG,1,2,3\n$GPXGA,1,2\n");
        // mode change in the middle of a line
        push_text("$GPGGA,1,2,");
        drain();
        write_mode(MODE_ALTITUDE);
        push_text("3,4,5,6,7,8,9.5,M\n");
        drain();
        write_mode(MODE_SPEED);
        push_text("$GPVTG,,T,,M,0.1,N,12.5,K*4\n$GPGGA,1,2,3\n");
        drain();
        write_mode(MODE_NONE);
        push_text("$GPGGA,1,2,3,4\n$GPVTG,,,,,,,1\n");
        drain();
        write_mode(MODE_POSITION);
        push_long_line(1'b0);

        // random phases, one mode each
        budget = (TARGET_ITEMS - pushed) / 6;
        for (p = 0; p < 6; p++) begin
            drain();
            write_mode(phase_modes[p]);
            start = pushed;
            while (pushed - start < budget) begin
                r = $urandom_range(0, 99);
                if (r < 40)
                    push_sentence(1'b0, $urandom_range(0, 14), 1'b0);
                else if (r < 70)
                    push_sentence(1'b1, $urandom_range(0, 14), 1'b0);
                else if (r < 82)
                    push_sentence(1'($urandom_range(0, 1)), $urandom_range(0, 10), 1'b1);
                else if (r < 99 || long_lines >= MAX_LONG_LINES)
                    push_noise_line();
                else
                    push_long_line(1'($urandom_range(0, 1)));
            end
        end

        drain();
        if (errors == 0)
            $display("PASS nmea_sentence_field_extractor_top");
        else
            $display("FAIL nmea_sentence_field_extractor_top");
        $finish;
    end

endmodule
